FILE: rtl/core/rgbx_pkg.sv
package rgbx_pkg;

  // item operation codes
  typedef enum logic [1:0] {
    OP_CONVERT      = 2'd0,
    OP_WRITE_IN     = 2'd1,
    OP_WRITE_OUT    = 2'd2,
    OP_WRITE_MATRIX = 2'd3
  } op_t;

  localparam int CODE_W     = 12;
  localparam int VALUE_W    = 16;
  localparam int OUT_W      = 12;
  localparam int SCALE_W    = 24;
  localparam int SCALE_HALF = 12;
  localparam int COEF_N     = 9;
  localparam int FRAC_SHIFT = 41;

  // widths along the datapath
  localparam int PROD_W  = 32;  // Q1.15 unsigned times Q2.14 signed
  localparam int SUM_W   = 34;  // three products
  localparam int PART_W  = SUM_W + SCALE_HALF + 1;
  localparam int FULL_W  = PART_W + SCALE_HALF;
  localparam int IDX_W   = FULL_W - FRAC_SHIFT;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd15372288;

  // what travels with an item down the pipeline
  typedef struct packed {
    logic              pix;
    logic              owr;
    logic [CODE_W-1:0] waddr;
    logic [OUT_W-1:0]  wdata;
  } tag_t;

endpackage

FILE: rtl/core/rgb_to_xyz_lut_matrix_converter.sv
// channel  | signals                                         | direction
// ---------+-------------------------------------------------+----------
// input    | in_valid, in_ready, in_operation .. in_blue      | in
// result   | out_valid, out_ready, out_x_out .. out_clamped   | out
// config   | cfg_we, cfg_wdata (companding scale)             | in
//
// One item per clock while no result waits at the output; a pixel passes the stages below in order.
// Input table read, matrix products, row sums, two scale partials, the full
// product and the output table read each take one pipeline stage.
// Reset is synchronous; the tables and matrix hold nothing until written.
// When a result waits at the output the whole pipeline holds, in_ready low.
module rgb_to_xyz_lut_matrix_converter #(
  parameter int IN_TABLE_DEPTH  = 4096,
  parameter int OUT_TABLE_DEPTH = 4096
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  rgbx_pkg::op_t                          in_operation,
  input  logic [rgbx_pkg::CODE_W-1:0]            in_table_address,
  input  logic [rgbx_pkg::VALUE_W-1:0]           in_table_value,
  input  logic [rgbx_pkg::CODE_W-1:0]            in_red,
  input  logic [rgbx_pkg::CODE_W-1:0]            in_green,
  input  logic [rgbx_pkg::CODE_W-1:0]            in_blue,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [rgbx_pkg::OUT_W-1:0]             out_x_out,
  output logic [rgbx_pkg::OUT_W-1:0]             out_y_out,
  output logic [rgbx_pkg::OUT_W-1:0]             out_z_out,
  output logic                                   out_clamped,
  input  logic                                   cfg_we,
  input  logic [rgbx_pkg::SCALE_W-1:0]           cfg_wdata
);
  import rgbx_pkg::*;

  localparam int IAW  = $clog2(IN_TABLE_DEPTH);
  localparam int OAW  = $clog2(OUT_TABLE_DEPTH);
  localparam int ICW  = (IAW > CODE_W) ? IAW : CODE_W;
  localparam int OCW  = (OAW > CODE_W) ? OAW : CODE_W;
  localparam int NSTG = 5;

  logic                      adv;
  logic                      in_acc;
  logic [SCALE_W-1:0]        scale_r;
  logic signed [VALUE_W-1:0] coef_r [COEF_N];
  tag_t                      tag_r [NSTG];
  tag_t                      tag_nxt;
  logic [CODE_W-1:0]         codes [3];
  logic [VALUE_W-1:0]        lin_r [3];
  logic signed [PROD_W-1:0]  prod_r [COEF_N];
  logic signed [SUM_W-1:0]   sum_r [3];
  logic signed [PART_W-1:0]  phi_r [3];
  logic signed [PART_W-1:0]  plo_r [3];
  logic signed [FULL_W-1:0]  full_r [3];
  logic [OAW-1:0]            oidx [3];
  logic [2:0]                clip;
  logic [OUT_W-1:0]          odata_r [3];
  logic                      out_valid_r;
  logic                      out_clamped_r;
  logic [ICW-1:0]            in_waddr_ext;
  logic                      in_wr;
  logic [OCW-1:0]            out_waddr_ext;
  logic                      out_wr;

  // global stall: everything moves when the output can take an item
  assign adv      = out_ready || !out_valid_r;
  assign in_ready = adv;
  assign in_acc   = in_valid && adv;

  assign codes[0] = in_red;
  assign codes[1] = in_green;
  assign codes[2] = in_blue;

  // companding scale register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SCALE_RESET;
    end else if (cfg_we) begin
      scale_r <= cfg_wdata;
    end
  end

  // matrix coefficients, written on acceptance
  always_ff @(posedge clk) begin
    if (in_acc && in_operation == OP_WRITE_MATRIX &&
        32'(in_table_address) < 32'(COEF_N)) begin
      coef_r[in_table_address[3:0]] <= in_table_value;
    end
  end

  // input table write, applied to every lane copy
  assign in_waddr_ext = ICW'(in_table_address);
  assign in_wr        = in_acc && in_operation == OP_WRITE_IN &&
                        32'(in_table_address) < 32'(IN_TABLE_DEPTH);

  // pipeline tag for the accepted item
  always_comb begin
    tag_nxt       = '0;
    tag_nxt.pix   = in_acc && in_operation == OP_CONVERT;
    tag_nxt.owr   = in_acc && in_operation == OP_WRITE_OUT;
    tag_nxt.waddr = in_table_address;
    tag_nxt.wdata = in_table_value[OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NSTG; s++) begin
        tag_r[s] <= '0;
      end
    end else if (adv) begin
      tag_r[0] <= tag_nxt;
      for (int s = 1; s < NSTG; s++) begin
        tag_r[s] <= tag_r[s-1];
      end
    end
  end

  // per-channel lanes: input table copy, row sum, scaling, output table copy
  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic [VALUE_W-1:0] in_mem [IN_TABLE_DEPTH];
    logic [OUT_W-1:0]   out_mem [OUT_TABLE_DEPTH];
    logic [IAW-1:0]     raddr;
    logic [ICW-1:0]     code_ext;
    logic               neg;
    logic               neg_big;
    logic               over;
    logic [IDX_W-1:0]   ipart;

    // code values beyond the table read its last entry
    assign code_ext = ICW'(codes[l]);
    assign raddr = (32'(codes[l]) >= 32'(IN_TABLE_DEPTH)) ?
                   IAW'(IN_TABLE_DEPTH - 1) : code_ext[IAW-1:0];

    always_ff @(posedge clk) begin
      if (in_wr) begin
        in_mem[in_waddr_ext[IAW-1:0]] <= in_table_value;
      end
      if (adv) begin
        lin_r[l] <= in_mem[raddr];
      end
    end

    // linear value times each coefficient of column l
    for (genvar r = 0; r < 3; r++) begin : g_mul
      logic signed [PROD_W:0] ea;
      logic signed [PROD_W:0] ec;
      logic signed [PROD_W:0] pp;
      assign ea = $signed({{(PROD_W+1-VALUE_W){1'b0}}, lin_r[l]});
      assign ec = (PROD_W+1)'(coef_r[r*3+l]);
      assign pp = ea * ec;
      always_ff @(posedge clk) begin
        if (adv) begin
          prod_r[r*3+l] <= pp[PROD_W-1:0];
        end
      end
    end

    // row sum, then the two halves of the scale product
    always_ff @(posedge clk) begin
      if (adv) begin
        sum_r[l] <= SUM_W'(prod_r[l*3]) + SUM_W'(prod_r[l*3+1]) +
                    SUM_W'(prod_r[l*3+2]);
        phi_r[l] <= PART_W'(sum_r[l]) *
                    $signed({{(PART_W-SCALE_HALF){1'b0}}, scale_r[SCALE_W-1:SCALE_HALF]});
        plo_r[l] <= PART_W'(sum_r[l]) *
                    $signed({{(PART_W-SCALE_HALF){1'b0}}, scale_r[SCALE_HALF-1:0]});
        full_r[l] <= (FULL_W'(phi_r[l]) <<< SCALE_HALF) + FULL_W'(plo_r[l]);
      end
    end

    // truncate toward zero and clamp into output table range
    assign neg     = full_r[l][FULL_W-1];
    assign ipart   = full_r[l][FULL_W-1:FRAC_SHIFT];
    assign neg_big = neg && !((&ipart) && (|full_r[l][FRAC_SHIFT-1:0]));
    assign over    = !neg && (32'(ipart) > 32'(OUT_TABLE_DEPTH - 1));
    assign clip[l] = neg_big || over;

    always_comb begin
      if (neg) begin
        oidx[l] = '0;
      end else if (over) begin
        oidx[l] = OAW'(OUT_TABLE_DEPTH - 1);
      end else begin
        oidx[l] = OAW'(ipart);
      end
    end

    // output table: written and read at the same stage to keep item order
    always_ff @(posedge clk) begin
      if (out_wr) begin
        out_mem[out_waddr_ext[OAW-1:0]] <= tag_r[NSTG-1].wdata;
      end
      if (adv) begin
        odata_r[l] <= out_mem[oidx[l]];
      end
    end
  end

  assign out_waddr_ext = OCW'(tag_r[NSTG-1].waddr);
  assign out_wr        = adv && tag_r[NSTG-1].owr &&
                         32'(tag_r[NSTG-1].waddr) < 32'(OUT_TABLE_DEPTH);

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= tag_r[NSTG-1].pix;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_clamped_r <= |clip;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_x_out   = odata_r[0];
  assign out_y_out   = odata_r[1];
  assign out_z_out   = odata_r[2];
  assign out_clamped = out_clamped_r;

endmodule
